### rtl/csfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfb_pkg: shared types and constants of the colour streak frame blender
// Holds the field widths, register indexes, reset values, the controller to
// datapath command and status structs and a small divide-by-three helper.
// ----------------------------------------------------------------------------
package csfb_pkg;

    localparam int CH_W       = 8;
    localparam int STORE_W    = 7;
    localparam int TDATA_W    = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int BLEND_W    = 2;
    localparam int DELAY_W    = 5;
    localparam int FPIX_W     = 13;

    localparam logic [CFG_ADDR_W-1:0] REG_BLEND_SHIFT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_STEP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PIXELS = 2'd2;

    localparam logic [BLEND_W-1:0] BLEND_RESET = 2'd2;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 5'd8;
    localparam logic [FPIX_W-1:0]  FPIX_RESET  = 13'd4096;

    typedef struct packed {
        logic start;     // input transaction accepted
        logic prime_wr;  // write one plane of the priming sweep
        logic norm_wr;   // write the current plane
        logic rd_issue;  // issue one delayed-plane read
        logic finish;    // load the result and advance frame state
    } cmd_t;

    typedef struct packed {
        logic priming;
        logic prime_last;
        logic read_last;
        logic out_free;
    } sts_t;

    // floor(x / 3) for x below 128.
    function automatic logic [6:0] div3(input logic [6:0] x);
        logic [13:0] prod;
        begin
            prod = {7'd0, x} * 14'd43;
            div3 = prod[13:7];
        end
    endfunction

endpackage

### rtl/csfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfb_ram: single-port frame store
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module csfb_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 131072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/csfb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfb_ctrl: sequencing state machine
// Steps one pixel through the priming sweep or the write and delayed reads,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module csfb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  csfb_pkg::sts_t  sts,
    output csfb_pkg::cmd_t  cmd
);
    import csfb_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        PRIME,
        WRITE,
        READ,
        DRAIN,
        FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   start;

    assign start = s_tvalid && ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= sts.priming ? PRIME : WRITE;
                        ready_reg <= 1'b0;
                    end
                end
                PRIME:
                begin
                    if (sts.prime_last)
                    begin
                        state_reg <= FINISH;
                    end
                end
                WRITE:
                begin
                    state_reg <= READ;
                end
                READ:
                begin
                    if (sts.read_last)
                    begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN:
                begin
                    state_reg <= FINISH;
                end
                FINISH:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.start    = start;
        cmd.prime_wr = (state_reg == PRIME);
        cmd.norm_wr  = (state_reg == WRITE);
        cmd.rd_issue = (state_reg == READ);
        cmd.finish   = (state_reg == FINISH) && sts.out_free;
    end

    assign s_tready = ready_reg;

    a_ready_idle : assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (state_reg == IDLE))
        else $error("ready out of step with controller state");

    a_drain_after_read : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DRAIN |-> $past(state_reg == READ))
        else $error("drain entered without a read sweep");

    a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !ready_reg)
        else $error("ready stayed high after an accepted transaction");

endmodule

### rtl/csfb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfb_datapath: frame stores, configuration, frame state and accumulators
// Three plane rings (one per channel), offset arithmetic for the delayed
// planes, per-channel sums and the output register.
// ----------------------------------------------------------------------------
module csfb_datapath #(
    parameter int NUM_PLANES = 32,
    parameter int MAX_PIXELS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csfb_pkg::cmd_t                      cmd,
    output csfb_pkg::sts_t                      sts,
    input  logic                                cfg_we,
    input  logic [csfb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [csfb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [csfb_pkg::TDATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [csfb_pkg::TDATA_W-1:0]        m_tdata,
    output logic                                m_tlast
);
    import csfb_pkg::*;

    localparam int PL_W   = $clog2(NUM_PLANES);
    localparam int PIX_W  = $clog2(MAX_PIXELS);
    localparam int ADDR_W = PL_W + PIX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = (PIX_W + 1 > FPIX_W) ? PIX_W + 1 : FPIX_W;
    localparam int DW     = (PL_W + 1 > DELAY_W) ? PL_W + 1 : DELAY_W;

    // Configuration registers.
    logic [BLEND_W-1:0] blend_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [FPIX_W-1:0]  fpix_reg;

    // Frame state.
    logic [PL_W-1:0]  ptr_reg;
    logic [PIX_W-1:0] idx_reg;
    logic             priming_reg;

    // Per-pixel working registers.
    logic [STORE_W-1:0] vr_reg, vg_reg, vb_reg;
    logic [CH_W-1:0]    acc_r_reg, acc_g_reg, acc_b_reg;
    logic [PL_W-1:0]    step_reg;
    logic [PL_W-1:0]    off_reg;
    logic               rd_vld_reg;

    // Output register.
    logic [CH_W-1:0] out_r_reg, out_g_reg, out_b_reg;
    logic            out_last_reg;
    logic            out_vld_reg;

    logic [BLEND_W-1:0] eff_b;
    logic [PL_W:0]      dmax;
    logic [PL_W-1:0]    dly;
    logic [PL_W-1:0]    cur;
    logic [CNT_W-1:0]   len;
    logic [CNT_W-1:0]   fp_ext;
    logic               last;
    logic [CH_W-1:0]    red_x, green_x, blue_x;
    logic [PL_W-1:0]    wr_plane;
    logic [PL_W-1:0]    rd_plane_r, rd_plane_g, rd_plane_b;
    logic [ADDR_W-1:0]  addr_r, addr_g, addr_b;
    logic               ram_we;
    logic [STORE_W-1:0] rdata_r, rdata_g, rdata_b;
    logic [2:0]         count_m1;

    function automatic logic [PL_W-1:0] plane_behind(input logic [PL_W-1:0] c,
                                                     input logic [PL_W-1:0] o);
        logic [PL_W:0] t;
        begin
            t = {1'b0, c} + (PL_W+1)'(NUM_PLANES) - {1'b0, o};
            if (t >= (PL_W+1)'(NUM_PLANES))
            begin
                t = t - (PL_W+1)'(NUM_PLANES);
            end
            plane_behind = t[PL_W-1:0];
        end
    endfunction

    always_comb
    begin
        eff_b = (blend_reg == '0) ? BLEND_W'(1) : blend_reg;
        dmax  = (PL_W+1)'(NUM_PLANES) >> eff_b;
        if (DW'(delay_reg) < DW'(dmax))
        begin
            dly = PL_W'(delay_reg);
        end
        else
        begin
            dly = dmax[PL_W-1:0];
        end
        cur    = priming_reg ? '0 : ptr_reg;
        fp_ext = CNT_W'(fpix_reg);
        if (fpix_reg == '0)
        begin
            len = CNT_W'(1);
        end
        else if (fp_ext > CNT_W'(MAX_PIXELS))
        begin
            len = CNT_W'(MAX_PIXELS);
        end
        else
        begin
            len = fp_ext;
        end
        last     = (CNT_W'(idx_reg) + CNT_W'(1)) >= len;
        count_m1 = 3'((4'd1 << eff_b) - 4'd1);
        red_x    = s_tdata[7:0] >> eff_b;
        green_x  = s_tdata[15:8] >> eff_b;
        blue_x   = s_tdata[23:16] >> eff_b;
    end

    // Read offsets: red d*j, green d*j/2, blue d*j/3.
    always_comb
    begin
        wr_plane   = cmd.prime_wr ? step_reg : cur;
        rd_plane_r = plane_behind(cur, off_reg);
        rd_plane_g = plane_behind(cur, off_reg >> 1);
        rd_plane_b = plane_behind(cur, PL_W'(div3(7'(off_reg))));
        ram_we     = cmd.prime_wr || cmd.norm_wr;
        addr_r     = ram_we ? {wr_plane, idx_reg} : {rd_plane_r, idx_reg};
        addr_g     = ram_we ? {wr_plane, idx_reg} : {rd_plane_g, idx_reg};
        addr_b     = ram_we ? {wr_plane, idx_reg} : {rd_plane_b, idx_reg};
    end

    csfb_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_ram_r (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_r),
        .wdata (vr_reg),
        .rdata (rdata_r)
    );

    csfb_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_ram_g (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_g),
        .wdata (vg_reg),
        .rdata (rdata_g)
    );

    csfb_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_b),
        .wdata (vb_reg),
        .rdata (rdata_b)
    );

    // Configuration and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg   <= BLEND_RESET;
            delay_reg   <= DELAY_RESET;
            fpix_reg    <= FPIX_RESET;
            ptr_reg     <= '0;
            idx_reg     <= '0;
            priming_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BLEND_SHIFT:
                    begin
                        blend_reg   <= cfg_wdata[BLEND_W-1:0];
                        priming_reg <= 1'b1;
                        ptr_reg     <= '0;
                        idx_reg     <= '0;
                    end
                    REG_DELAY_STEP:
                    begin
                        delay_reg <= cfg_wdata[DELAY_W-1:0];
                    end
                    REG_FRAME_PIXELS:
                    begin
                        fpix_reg <= cfg_wdata[FPIX_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.finish)
            begin
                if (last)
                begin
                    idx_reg     <= '0;
                    priming_reg <= 1'b0;
                    if (cur == PL_W'(NUM_PLANES - 1))
                    begin
                        ptr_reg <= '0;
                    end
                    else
                    begin
                        ptr_reg <= cur + PL_W'(1);
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + PIX_W'(1);
                end
            end
        end
    end

    // Pixel working registers; the zero-offset term is the value just written.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            vr_reg    <= red_x[STORE_W-1:0];
            vg_reg    <= green_x[STORE_W-1:0];
            vb_reg    <= blue_x[STORE_W-1:0];
            acc_r_reg <= priming_reg ? (red_x << eff_b) : red_x;
            acc_g_reg <= priming_reg ? (green_x << eff_b) : green_x;
            acc_b_reg <= priming_reg ? (blue_x << eff_b) : blue_x;
            step_reg  <= '0;
        end
        else
        begin
            if (cmd.prime_wr)
            begin
                step_reg <= step_reg + PL_W'(1);
            end
            else if (cmd.norm_wr)
            begin
                step_reg <= PL_W'(1);
                off_reg  <= dly;
            end
            else if (cmd.rd_issue)
            begin
                step_reg <= step_reg + PL_W'(1);
                off_reg  <= off_reg + dly;
            end
            if (rd_vld_reg)
            begin
                acc_r_reg <= acc_r_reg + CH_W'(rdata_r);
                acc_g_reg <= acc_g_reg + CH_W'(rdata_g);
                acc_b_reg <= acc_b_reg + CH_W'(rdata_b);
            end
        end
        if (cmd.finish)
        begin
            out_r_reg    <= acc_r_reg;
            out_g_reg    <= acc_g_reg;
            out_b_reg    <= acc_b_reg;
            out_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_issue;
            if (cmd.finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.priming    = priming_reg;
        sts.prime_last = (step_reg == PL_W'(NUM_PLANES - 1));
        sts.read_last  = (step_reg == PL_W'(count_m1));
        sts.out_free   = !out_vld_reg || m_tready;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_b_reg, out_g_reg, out_r_reg};
    assign m_tlast  = out_last_reg;

    a_ptr_range : assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PL_W'(NUM_PLANES - 1))
        else $error("plane pointer outside the ring");

    a_finish_shows : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_tvalid)
        else $error("finished pixel not presented");

    a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> !ram_we)
        else $error("store write during pending read sweep");

endmodule

### rtl/colour_streak_frame_blend_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colour_streak_frame_blend_top: temporal colour streak blender
// Each channel is scaled down and written into a ring of frame planes; the
// output sums 2^max(blend,1) planes per channel at per-channel delay spacings.
// ----------------------------------------------------------------------------
// One pixel is processed at a time. In a normal frame the controller steps
// from the accepting idle state through one write of the current plane,
// then 2^max(blend,1) - 1 reads of the delayed planes, one per cycle, because
// each channel's frame store is a single-ported memory read at one address
// per cycle, then a drain state that collects the last read and a finish
// state that loads the result into the output register; the next pixel can
// be accepted in the cycle after the result is loaded. During the priming
// frame (after reset or a blend_shift write) every pixel is written into all
// NUM_PLANES planes, one plane per cycle, before the finish state loads the
// result. The output register lets a new pixel be accepted while the
// previous result waits; a pixel that finishes while that result is still
// waiting holds until the output register frees up. Store contents are
// undefined after reset; the priming frame fills them.
// ----------------------------------------------------------------------------
module colour_streak_frame_blend_top #(
    parameter int NUM_PLANES = 32,
    parameter int MAX_PIXELS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csfb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [csfb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [csfb_pkg::TDATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic [csfb_pkg::TDATA_W-1:0]        m_tdata,
    output logic                                m_tlast
);
    import csfb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    csfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csfb_datapath #(
        .NUM_PLANES (NUM_PLANES),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### verif/colour_streak_frame_blend_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colour_streak_frame_blend_top_tb: self-checking bench for the streak blender
// Sends RGB pixels over the input stream and predicts every blended result
// with a private copy of the plane ring and frame counters. Directed frames
// cover reset values, register extremes, delay saturation and frame
// shrinking. Random frames follow under several idle and stall mixes, and
// one long output hold-off. Config writes happen only while the block is idle.
// ----------------------------------------------------------------------------
module colour_streak_frame_blend_top_tb;

    import csfb_pkg::*;

    localparam int PLANES        = 32;
    localparam int PIXELS        = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int LATENCY       = PLANES + 4;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_out_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;

    // Mirror of the block's registers and frame state.
    logic [BLEND_W-1:0] blend_reg = BLEND_RESET;
    logic [DELAY_W-1:0] delay_reg = DELAY_RESET;
    logic [FPIX_W-1:0]  fpix_reg  = FPIX_RESET;
    int                 plane_ptr = 0;
    int                 pix_idx   = 0;
    bit                 priming   = 1'b1;
    // Pixel positions below this were written into every plane by a priming frame.
    int                 primed_len = 0;

    bit [6:0] red_mem   [PLANES][PIXELS];
    bit [6:0] green_mem [PLANES][PIXELS];
    bit [6:0] blue_mem  [PLANES][PIXELS];

    pixel_out_t blended_results[$];

    int src_idle_pct   = 0;
    int snk_stall_pct  = 0;
    int hold_cycles    = 0;
    int items_sent     = 0;
    int primed_pixels  = 0;
    int results_seen   = 0;
    int frames_seen    = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;

    colour_streak_frame_blend_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int frame_len_eff();
        int flen;
        flen = fpix_reg;
        if (flen == 0)
            flen = 1;
        if (flen > PIXELS)
            flen = PIXELS;
        return flen;
    endfunction

    // Stores the scaled pixel, sums the delayed planes and advances frame state.
    function automatic pixel_out_t blend_pixel(input logic [7:0] r_in, g_in, b_in);
        int         shift, terms, dmax, dly, pos, cur, plane;
        int         rv, gv, bv, rsum, gsum, bsum;
        pixel_out_t res;
        shift = (blend_reg == 0) ? 1 : int'(blend_reg);
        terms = 1 << shift;
        dmax  = PLANES >> shift;
        dly   = (int'(delay_reg) < dmax) ? int'(delay_reg) : dmax;
        pos   = (pix_idx < PIXELS) ? pix_idx : PIXELS - 1;
        cur   = priming ? 0 : plane_ptr;
        rv    = int'(r_in) >> shift;
        gv    = int'(g_in) >> shift;
        bv    = int'(b_in) >> shift;
        if (priming)
        begin
            for (int p = 0; p < PLANES; p++)
            begin
                red_mem[p][pos]   = rv[6:0];
                green_mem[p][pos] = gv[6:0];
                blue_mem[p][pos]  = bv[6:0];
            end
            if (pos + 1 > primed_len)
                primed_len = pos + 1;
        end
        else
        begin
            red_mem[cur][pos]   = rv[6:0];
            green_mem[cur][pos] = gv[6:0];
            blue_mem[cur][pos]  = bv[6:0];
        end
        rsum = 0;
        gsum = 0;
        bsum = 0;
        for (int j = 0; j < terms; j++)
        begin
            plane = (cur + PLANES - (dly * j) % PLANES) % PLANES;
            rsum += red_mem[plane][pos];
            plane = (cur + PLANES - (dly * j / 2) % PLANES) % PLANES;
            gsum += green_mem[plane][pos];
            plane = (cur + PLANES - (dly * j / 3) % PLANES) % PLANES;
            bsum += blue_mem[plane][pos];
        end
        res.red   = rsum[7:0];
        res.green = gsum[7:0];
        res.blue  = bsum[7:0];
        res.last  = (pix_idx + 1 >= frame_len_eff());
        if (res.last)
        begin
            pix_idx   = 0;
            plane_ptr = (cur + 1) % PLANES;
            priming   = 1'b0;
        end
        else
            pix_idx = pix_idx + 1;
        return res;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offers one pixel, possibly after random idle cycles, and records its result.
    task automatic send_pixel(input logic [7:0] r, g, b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do
            @(posedge clk);
        while (!s_tready);
        if (priming)
            primed_pixels++;
        blended_results.push_back(blend_pixel(r, g, b));
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (blended_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BLEND_SHIFT:
            begin
                blend_reg = val[BLEND_W-1:0];
                priming   = 1'b1;
                plane_ptr = 0;
                pix_idx   = 0;
            end
            REG_DELAY_STEP:   delay_reg = val[DELAY_W-1:0];
            REG_FRAME_PIXELS: fpix_reg  = val[FPIX_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++)
            send_pixel(rand_chan(), rand_chan(), rand_chan());
    endtask

    // Reset values: a priming frame at the full frame length, cut short by
    // shrinking the frame, then two short normal frames.
    task automatic test_reset_config();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hA5, 8'h5A, 8'h3C);
        write_reg(REG_FRAME_PIXELS, 3);
        send_pixel(8'h81, 8'h7E, 8'hC3);
        send_random(6);
    endtask

    // Blend of zero acts as one, oversized delays saturate, a zero frame
    // length acts as one, and a zero delay sums the current plane only.
    task automatic test_blend_delay_limits();
        write_reg(REG_BLEND_SHIFT, 0);
        write_reg(REG_DELAY_STEP, 31);
        write_reg(REG_FRAME_PIXELS, 0);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_random(3);
        write_reg(REG_BLEND_SHIFT, 3);
        write_reg(REG_FRAME_PIXELS, 2);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_random(4);
        write_reg(REG_DELAY_STEP, 0);
        send_random(3);
    endtask

    // Frame lengths beyond the store size clamp; only the first few pixels are
    // sent before the frame is shrunk so that it ends early.
    task automatic test_large_frame_shrink();
        write_reg(REG_BLEND_SHIFT, 1);
        write_reg(REG_FRAME_PIXELS, 8191);
        send_random(3);
        write_reg(REG_FRAME_PIXELS, 4096);
        send_random(1);
        write_reg(REG_FRAME_PIXELS, 2);
        send_random(1);
    endtask

    // The receiver holds off long enough for the output register and the
    // pixel in flight to fill, so the input stream has to stall.
    task automatic test_output_hold_off();
        write_reg(REG_DELAY_STEP, 5);
        write_reg(REG_FRAME_PIXELS, (primed_len < 4) ? primed_len : 4);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_cycles   = 300;
        send_random(24);
        drain_results();
    endtask

    task automatic run_random_phase(input int src_pct, input int snk_pct, input int n_items);
        int sent;
        int burst;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(3) == 0)
                write_reg(REG_BLEND_SHIFT, $urandom_range(3));
            if ($urandom_range(1) == 0)
                write_reg(REG_DELAY_STEP, $urandom_range(31));
            // Outside a priming frame the length must stay within the primed
            // positions, so no plane entry is read before it was written.
            if ($urandom_range(1) == 0 || (!priming && frame_len_eff() > primed_len))
            begin
                if (priming)
                    write_reg(REG_FRAME_PIXELS, $urandom_range(24));
                else
                    write_reg(REG_FRAME_PIXELS, $urandom_range(primed_len));
            end
            burst = $urandom_range(8, 60);
            send_random(burst);
            sent += burst;
        end
        drain_results();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_blend_delay_limits();
        test_large_frame_shrink();
        test_output_hold_off();
        run_random_phase(0, 0, 500);
        run_random_phase(81, 0, 500);
        run_random_phase(0, 81, 500);
        run_random_phase(33, 33, 500);
        drain_results();
        repeat (LATENCY) @(posedge clk);
        $display("Run covered %0d pixels (%0d in priming frames) over %0d frame ends,",
                 items_sent, primed_pixels, frames_seen);
        $display("with %0d blended results compared and %0d errors.",
                 results_seen, err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Output side: compares each result transaction and drives tready.
    always @(posedge clk)
    begin : result_sink
        pixel_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (blended_results.size() == 0)
            begin
                if (err_count < 10)
                    $display("ERROR: result transaction with none expected, data %h last %b",
                             m_tdata, m_tlast);
                err_count++;
            end
            else
            begin
                want = blended_results.pop_front();
                results_seen++;
                if (m_tlast)
                    frames_seen++;
                if (m_tdata[7:0] !== want.red || m_tdata[15:8] !== want.green ||
                    m_tdata[23:16] !== want.blue || m_tlast !== want.last)
                begin
                    if (err_count < 10)
                        $display("ERROR: result %0d expected r %h g %h b %h last %b, got r %h g %h b %h last %b",
                                 results_seen, want.red, want.green, want.blue, want.last,
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast);
                    err_count++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

### files.f
rtl/csfb_pkg.sv
rtl/csfb_ram.sv
rtl/csfb_ctrl.sv
rtl/csfb_datapath.sv
rtl/colour_streak_frame_blend_top.sv
verif/colour_streak_frame_blend_top_tb.sv
